/* sv/priority_competition_table_defines.svh */
// Assertion macros for the checker file pct_checker.sv.
`ifndef PRIORITY_COMPETITION_TABLE_DEFINES_SVH
`define PRIORITY_COMPETITION_TABLE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/pct_pkg.sv */
package pct_pkg;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int MOD_W    = 32;
  localparam int PRI_W    = 16;
  localparam int TYPE_W   = 8;
  localparam int HND_W    = 32;
  localparam int SIZE_W   = 16;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_COMPETE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BCAST   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_PENDING = 3'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_LOW = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd4;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PRI   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO      = 2'd2;

  localparam logic [PRI_W-1:0] BCAST_THR_RST = 16'd128;
  localparam logic [PRI_W-1:0] MIN_PRI_RST   = 16'd26;

  // One table entry
  typedef struct packed {
    logic [MOD_W-1:0]  bidder_id;
    logic [PRI_W-1:0]  prio;
    logic [TYPE_W-1:0] ctype;
    logic [HND_W-1:0]  handle;
    logic [SIZE_W-1:0] size;
  } pct_slot_t;

  // Scan unit control
  typedef struct packed {
    logic clear;
    logic vld;
    logic pend;
  } pct_scan_ctrl_t;

  // Scan unit findings
  typedef struct packed {
    logic match;
    logic free;
    logic higher;
    logic best;
  } pct_scan_flags_t;

endpackage

/* sv/pct_cfg_if.sv */
interface pct_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pct_pkg::CFG_IDX_W-1:0]    index;
  logic [pct_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/pct_in_if.sv */
interface pct_in_if;
  logic                          valid;
  logic                          ready;
  logic [pct_pkg::CMD_W-1:0]     command;
  logic [pct_pkg::MOD_W-1:0]     bidder_id;
  logic [pct_pkg::PRI_W-1:0]     priority_req;
  logic [pct_pkg::TYPE_W-1:0]    payload_kind;
  logic [pct_pkg::HND_W-1:0]     content_handle;
  logic [pct_pkg::SIZE_W-1:0]    payload_len;

  modport source (output valid, output command, output bidder_id, output priority_req,
                  output payload_kind, output content_handle, output payload_len,
                  input ready);
  modport sink   (input valid, input command, input bidder_id, input priority_req,
                  input payload_kind, input content_handle, input payload_len,
                  output ready);
endinterface

/* sv/pct_out_if.sv */
interface pct_out_if;
  logic                          valid;
  logic                          ready;
  logic [pct_pkg::STAT_W-1:0]    status;
  logic                          broadcast;
  logic [pct_pkg::MOD_W-1:0]     current_source;
  logic [pct_pkg::PRI_W-1:0]     current_priority;
  logic [pct_pkg::TYPE_W-1:0]    current_type;
  logic [pct_pkg::HND_W-1:0]     current_handle;
  logic [pct_pkg::SIZE_W-1:0]    current_size;
  logic [pct_pkg::CNT_W-1:0]     pending_count;

  modport source (output valid, output status, output broadcast, output current_source,
                  output current_priority, output current_type, output current_handle,
                  output current_size, output pending_count, input ready);
  modport sink   (input valid, input status, input broadcast, input current_source,
                  input current_priority, input current_type, input current_handle,
                  input current_size, input pending_count, output ready);
endinterface

/* sv/priority_competition_table.sv */
// Channel   | Dir | Payload                                               | Transfer
// cfg_i     | in  | index, data (threshold, min priority, auto resolve)   | valid & ready
// in_i      | in  | command, bidder_id, priority_req, content fields      | valid & ready
// out_o     | out | status, broadcast, current content, pending_count     | valid & ready
//
// Compete: one table pass from transfer to result; a second pass when it resolves.
// Resolve: one table pass. Direct broadcast, unknown command, low bid: no table pass.
// Each pass reads the table memory one entry per cycle into one compare unit.
// Reset clears control, pending bits, current content and the count; no clearing pass.
// The output register holds a stalled result while the next item is taken.
module priority_competition_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pct_cfg_if.sink     cfg_i,
  pct_in_if.sink      in_i,
  pct_out_if.source   out_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_POST = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Scan purpose
  localparam logic MODE_FIND = 1'b0;
  localparam logic MODE_PICK = 1'b1;

  logic [2:0]                  state_q, state_d;
  logic                        mode_q, mode_d;
  logic [IW-1:0]               idx_q, idx_d;
  logic                        rd_vld_q;
  logic [IW-1:0]               rd_idx_q;
  logic                        rd_pend_q;
  pct_pkg::pct_slot_t          rd_q;

  logic [pct_pkg::PRI_W-1:0]   thr_q, minpri_q;
  logic                        auto_q;

  pct_pkg::pct_slot_t          key_q;
  logic                        key_ld;

  pct_pkg::pct_slot_t          mem_q [SLOTS];
  logic                        mem_we;
  logic [IW-1:0]               slot_sel;
  logic [SLOTS-1:0]            pend_q;
  logic                        pend_clr;

  logic [pct_pkg::MOD_W-1:0]   held_src_q, held_src_d;
  logic [pct_pkg::PRI_W-1:0]   held_pri_q, held_pri_d;
  logic [pct_pkg::TYPE_W-1:0]  held_type_q, held_type_d;
  logic [pct_pkg::HND_W-1:0]   held_hnd_q, held_hnd_d;
  logic [pct_pkg::SIZE_W-1:0]  held_size_q, held_size_d;
  logic [pct_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  logic [pct_pkg::STAT_W-1:0]  res_stat_q, res_stat_d;
  logic                        res_bc_q, res_bc_d;

  logic                        out_vld_q, out_vld_d, out_ld;
  logic [pct_pkg::STAT_W-1:0]  o_stat_q;
  logic                        o_bc_q;
  logic [pct_pkg::MOD_W-1:0]   o_src_q;
  logic [pct_pkg::PRI_W-1:0]   o_pri_q;
  logic [pct_pkg::TYPE_W-1:0]  o_type_q;
  logic [pct_pkg::HND_W-1:0]   o_hnd_q;
  logic [pct_pkg::SIZE_W-1:0]  o_size_q;
  logic [pct_pkg::CNT_W-1:0]   o_cnt_q;

  pct_pkg::pct_scan_ctrl_t     scan_ctrl;
  pct_pkg::pct_scan_flags_t    scan_flags;
  logic [IW-1:0]               match_idx, free_idx;
  pct_pkg::pct_slot_t          best;

  logic                        in_xfer;

  assign in_xfer     = in_i.valid && in_i.ready;
  assign in_i.ready  = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= pct_pkg::BCAST_THR_RST;
      minpri_q <= pct_pkg::MIN_PRI_RST;
      auto_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pct_pkg::REG_BCAST_THR: thr_q    <= cfg_i.data;
        pct_pkg::REG_MIN_PRI:   minpri_q <= cfg_i.data;
        pct_pkg::REG_AUTO:      auto_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Latch the accepted bid
  assign key_ld = in_xfer;
  always_ff @(posedge clk_i) begin
    if (key_ld) begin
      key_q.bidder_id <= in_i.bidder_id;
      key_q.prio      <= in_i.priority_req;
      key_q.ctype     <= in_i.payload_kind;
      key_q.handle    <= in_i.content_handle;
      key_q.size      <= in_i.payload_len;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[slot_sel] <= key_q;
    rd_q <= mem_q[idx_q];
  end

  // Align the pending bit and index with the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_vld_q  <= state_q == S_SCAN;
      rd_idx_q  <= idx_q;
      rd_pend_q <= pend_q[idx_q];
    end
  end

  // Pending bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (pend_clr) begin
      pend_q <= '0;
    end else if (mem_we) begin
      pend_q[slot_sel] <= 1'b1;
    end
  end

  // Feed the compare unit; clear it on the first address of a pass
  always_comb begin
    scan_ctrl.clear = (state_q == S_SCAN) && (idx_q == '0) && !rd_vld_q;
    scan_ctrl.vld   = rd_vld_q;
    scan_ctrl.pend  = rd_pend_q;
  end

  pct_scan #(
    .IW (IW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .idx_i       (rd_idx_q),
    .entry_i     (rd_q),
    .key_mod_i   (key_q.bidder_id),
    .key_pri_i   (key_q.prio),
    .flags_o     (scan_flags),
    .match_idx_o (match_idx),
    .free_idx_o  (free_idx),
    .best_o      (best)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    held_src_d  = held_src_q;
    held_pri_d  = held_pri_q;
    held_type_d = held_type_q;
    held_hnd_d  = held_hnd_q;
    held_size_d = held_size_q;
    cnt_d       = cnt_q;
    res_stat_d  = res_stat_q;
    res_bc_d    = res_bc_q;
    mem_we      = 1'b0;
    pend_clr    = 1'b0;
    slot_sel    = match_idx;
    out_ld      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          idx_d      = '0;
          res_stat_d = pct_pkg::STAT_OK;
          res_bc_d   = 1'b0;
          state_d    = S_DONE;
          case (in_i.command)
            pct_pkg::CMD_COMPETE: begin
              if ((in_i.priority_req < thr_q) || (in_i.priority_req < minpri_q)) begin
                res_stat_d = pct_pkg::STAT_TOO_LOW;
              end else begin
                mode_d  = MODE_FIND;
                state_d = S_SCAN;
              end
            end
            pct_pkg::CMD_RESOLVE: begin
              mode_d  = MODE_PICK;
              state_d = S_SCAN;
            end
            pct_pkg::CMD_BCAST: begin
              held_type_d = in_i.payload_kind;
              held_hnd_d  = (in_i.payload_len != '0) ? in_i.content_handle : '0;
              held_size_d = in_i.payload_len;
              res_bc_d    = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // Issue one read per cycle
      S_SCAN: begin
        if (idx_q == LastIdx) begin
          state_d = S_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Let the last entry go through the compare unit
      S_LAST: state_d = S_POST;

      S_POST: begin
        state_d = S_DONE;
        if (mode_q == MODE_FIND) begin
          if (scan_flags.match || scan_flags.free) begin
            slot_sel = scan_flags.match ? match_idx : free_idx;
            mem_we   = 1'b1;
            if (!scan_flags.match) cnt_d = cnt_q + 1'b1;
            if (!scan_flags.higher && auto_q) begin
              mode_d  = MODE_PICK;
              idx_d   = '0;
              state_d = S_SCAN;
            end else begin
              res_stat_d = pct_pkg::STAT_PENDING;
            end
          end else begin
            res_stat_d = pct_pkg::STAT_FULL;
          end
        end else begin
          if (scan_flags.best) begin
            held_src_d  = best.bidder_id;
            held_pri_d  = best.prio;
            held_type_d = best.ctype;
            held_hnd_d  = (best.size != '0) ? best.handle : '0;
            held_size_d = best.size;
            pend_clr    = 1'b1;
            cnt_d       = '0;
            res_stat_d  = pct_pkg::STAT_OK;
            res_bc_d    = 1'b1;
          end else begin
            res_stat_d = pct_pkg::STAT_EMPTY;
          end
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_ld  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and current content
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FIND;
      idx_q       <= '0;
      held_src_q  <= '0;
      held_pri_q  <= '0;
      held_type_q <= '0;
      held_hnd_q  <= '0;
      held_size_q <= '0;
      cnt_q       <= '0;
      res_stat_q  <= pct_pkg::STAT_OK;
      res_bc_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      held_src_q  <= held_src_d;
      held_pri_q  <= held_pri_d;
      held_type_q <= held_type_d;
      held_hnd_q  <= held_hnd_d;
      held_size_q <= held_size_d;
      cnt_q       <= cnt_d;
      res_stat_q  <= res_stat_d;
      res_bc_q    <= res_bc_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Output register
  assign out_vld_d = out_ld ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      o_stat_q <= res_stat_q;
      o_bc_q   <= res_bc_q;
      o_src_q  <= held_src_q;
      o_pri_q  <= held_pri_q;
      o_type_q <= held_type_q;
      o_hnd_q  <= held_hnd_q;
      o_size_q <= held_size_q;
      o_cnt_q  <= cnt_q;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.status           = o_stat_q;
  assign out_o.broadcast        = o_bc_q;
  assign out_o.current_source   = o_src_q;
  assign out_o.current_priority = o_pri_q;
  assign out_o.current_type     = o_type_q;
  assign out_o.current_handle   = o_hnd_q;
  assign out_o.current_size     = o_size_q;
  assign out_o.pending_count    = o_cnt_q;

endmodule

/* sv/pct_scan.sv */
// Shared compare unit: looks at one table entry per cycle and keeps the
// first module match, the first free slot, whether another bid outranks the
// key, and the first entry with the highest priority.
module pct_scan #(
  parameter int IW = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pct_pkg::pct_scan_ctrl_t     ctrl_i,
  input  logic [IW-1:0]               idx_i,
  input  pct_pkg::pct_slot_t          entry_i,
  input  logic [pct_pkg::MOD_W-1:0]   key_mod_i,
  input  logic [pct_pkg::PRI_W-1:0]   key_pri_i,
  output pct_pkg::pct_scan_flags_t    flags_o,
  output logic [IW-1:0]               match_idx_o,
  output logic [IW-1:0]               free_idx_o,
  output pct_pkg::pct_slot_t          best_o
);

  pct_pkg::pct_scan_flags_t flags_q, flags_d;
  logic [IW-1:0]            match_idx_q, free_idx_q;
  pct_pkg::pct_slot_t       best_q;
  logic                     same_mod, take_match, take_free, take_best;

  // Compare the current entry against the key and the running best
  always_comb begin
    same_mod   = entry_i.bidder_id == key_mod_i;
    take_match = ctrl_i.vld && ctrl_i.pend && same_mod && !flags_q.match;
    take_free  = ctrl_i.vld && !ctrl_i.pend && !flags_q.free;
    take_best  = ctrl_i.vld && ctrl_i.pend &&
                 (!flags_q.best || (entry_i.prio > best_q.prio));
    flags_d = flags_q;
    if (ctrl_i.clear) begin
      flags_d = '0;
    end else begin
      if (take_match) flags_d.match = 1'b1;
      if (take_free)  flags_d.free  = 1'b1;
      if (take_best)  flags_d.best  = 1'b1;
      if (ctrl_i.vld && ctrl_i.pend && !same_mod && (entry_i.prio > key_pri_i)) begin
        flags_d.higher = 1'b1;
      end
    end
  end

  // Hold the flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // Capture indexes and the leading entry
  always_ff @(posedge clk_i) begin
    if (!ctrl_i.clear && take_match) match_idx_q <= idx_i;
    if (!ctrl_i.clear && take_free)  free_idx_q  <= idx_i;
    if (!ctrl_i.clear && take_best)  best_q      <= entry_i;
  end

  assign flags_o     = flags_q;
  assign match_idx_o = match_idx_q;
  assign free_idx_o  = free_idx_q;
  assign best_o      = best_q;

endmodule

/* sv/pct_checker.sv */
`include "priority_competition_table_defines.svh"

// Port-level checks on the result channel.
module pct_checker #(
  parameter int SLOTS = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pct_pkg::STAT_W-1:0]   status,
  input logic                         broadcast,
  input logic [pct_pkg::MOD_W-1:0]    current_source,
  input logic [pct_pkg::HND_W-1:0]    current_handle,
  input logic [pct_pkg::SIZE_W-1:0]   current_size,
  input logic [pct_pkg::CNT_W-1:0]    pending_count
);

  // A stalled result holds
  `PCT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(current_source) && $stable(current_handle) && $stable(pending_count), "stalled result changed")

  // A broadcast always reports success
  `PCT_ASSERT(a_bcast_ok, out_valid && broadcast |-> status == pct_pkg::STAT_OK, "broadcast with failing status")

  // An empty resolve leaves no bids counted
  `PCT_ASSERT(a_empty_cnt, out_valid && status == pct_pkg::STAT_EMPTY |-> pending_count == '0 && !broadcast, "empty resolve with bids counted")

  // Content without payload carries no handle
  `PCT_ASSERT(a_no_payload, out_valid && current_size == '0 |-> current_handle == '0, "handle without payload")

  // Never report more bids than slots
  `PCT_ASSERT_ALWAYS(a_cnt_range, !out_valid || (int'(pending_count) <= SLOTS) || (SLOTS >= 32), "pending count above table size")

endmodule

bind priority_competition_table pct_checker #(
  .SLOTS (SLOTS)
) u_pct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .status         (out_o.status),
  .broadcast      (out_o.broadcast),
  .current_source (out_o.current_source),
  .current_handle (out_o.current_handle),
  .current_size   (out_o.current_size),
  .pending_count  (out_o.pending_count)
);

/* sim/priority_competition_checker.sv */
`timescale 1ns / 100ps

module priority_competition_checker #(
  parameter int SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  pct_cfg_if   cfg_i,
  pct_in_if    bid_i,
  pct_out_if   res_i,
  output int   outstanding_o,
  output int   fail_count_o
);

  // One result as the block should report it
  typedef struct packed {
    logic [pct_pkg::STAT_W-1:0] status;
    logic                       broadcast;
    logic [pct_pkg::MOD_W-1:0]  source;
    logic [pct_pkg::PRI_W-1:0]  prio;
    logic [pct_pkg::TYPE_W-1:0] ctype;
    logic [pct_pkg::HND_W-1:0]  handle;
    logic [pct_pkg::SIZE_W-1:0] size;
    logic [pct_pkg::CNT_W-1:0]  count;
  } bid_outcome_t;

  bid_outcome_t       awaited_q [$];
  bid_outcome_t       want;
  pct_pkg::pct_slot_t bid;

  // Shadow of the registers and the table
  logic [pct_pkg::PRI_W-1:0] thr_r;
  logic [pct_pkg::PRI_W-1:0] floor_r;
  logic                      auto_r;
  logic [SLOTS-1:0]          live_r;
  pct_pkg::pct_slot_t        entry_r [SLOTS];
  pct_pkg::pct_slot_t        held_r;
  logic [pct_pkg::CNT_W-1:0] count_r;

  // Make the first highest pending entry current and empty the table
  function automatic bit award_top_bid();
    int best;
    bit found;
    best  = 0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (live_r[i] && (!found || entry_r[i].prio > entry_r[best].prio)) begin
        found = 1'b1;
        best  = i;
      end
    end
    if (found) begin
      held_r = entry_r[best];
      if (held_r.size == '0) held_r.handle = '0;
      live_r  = '0;
      count_r = '0;
    end
    return found;
  endfunction

  // Advance the shadow state by one item and return its result
  function automatic bid_outcome_t predict_outcome(input logic [pct_pkg::CMD_W-1:0] cmd,
                                                   input pct_pkg::pct_slot_t item);
    bid_outcome_t res;
    int           slot;
    bit           have;
    bit           leads;
    res   = '0;
    slot  = 0;
    have  = 1'b0;
    leads = 1'b1;
    case (cmd)
      pct_pkg::CMD_COMPETE: begin
        if (item.prio < thr_r || item.prio < floor_r) begin
          res.status = pct_pkg::STAT_TOO_LOW;
        end else begin
          // reuse the bidder's own entry, else take the lowest free slot
          for (int i = 0; i < SLOTS; i++) begin
            if (!have && live_r[i] && entry_r[i].bidder_id == item.bidder_id) begin
              slot = i;
              have = 1'b1;
            end
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (!have && !live_r[i]) begin
              slot    = i;
              have    = 1'b1;
              count_r = count_r + 1'b1;
            end
          end
          if (!have) begin
            res.status = pct_pkg::STAT_FULL;
          end else begin
            live_r[slot]  = 1'b1;
            entry_r[slot] = item;
            for (int i = 0; i < SLOTS; i++) begin
              if (live_r[i] && i != slot && entry_r[i].prio > item.prio) leads = 1'b0;
            end
            if (leads && auto_r) begin
              have          = award_top_bid();
              res.status    = pct_pkg::STAT_OK;
              res.broadcast = 1'b1;
            end else begin
              res.status = pct_pkg::STAT_PENDING;
            end
          end
        end
      end
      pct_pkg::CMD_RESOLVE: begin
        if (award_top_bid()) begin
          res.status    = pct_pkg::STAT_OK;
          res.broadcast = 1'b1;
        end else begin
          res.status = pct_pkg::STAT_EMPTY;
        end
      end
      pct_pkg::CMD_BCAST: begin
        // source and priority of the current content stay
        held_r.ctype  = item.ctype;
        held_r.size   = item.size;
        held_r.handle = (item.size != '0) ? item.handle : '0;
        res.status    = pct_pkg::STAT_OK;
        res.broadcast = 1'b1;
      end
      default: begin
        res.status = pct_pkg::STAT_OK;
      end
    endcase
    res.source = held_r.bidder_id;
    res.prio   = held_r.prio;
    res.ctype  = held_r.ctype;
    res.handle = held_r.handle;
    res.size   = held_r.size;
    res.count  = count_r;
    return res;
  endfunction

  task automatic match_field(input string label, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", label, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  // Watch the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_r         = pct_pkg::BCAST_THR_RST;
      floor_r       = pct_pkg::MIN_PRI_RST;
      auto_r        = 1'b1;
      live_r        = '0;
      held_r        = '0;
      count_r       = '0;
      fail_count_o  = 0;
      outstanding_o = 0;
      awaited_q.delete();
    end else begin
      // compare a result transfer with the oldest expectation
      if (res_i.valid && res_i.ready) begin
        if (awaited_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          fail_count_o++;
        end else begin
          want = awaited_q.pop_front();
          match_field("status", 32'(want.status), 32'(res_i.status));
          match_field("broadcast", 32'(want.broadcast), 32'(res_i.broadcast));
          match_field("current_source", want.source, res_i.current_source);
          match_field("current_priority", 32'(want.prio), 32'(res_i.current_priority));
          match_field("current_type", 32'(want.ctype), 32'(res_i.current_type));
          match_field("current_handle", want.handle, res_i.current_handle);
          match_field("current_size", 32'(want.size), 32'(res_i.current_size));
          match_field("pending_count", 32'(want.count), 32'(res_i.pending_count));
        end
      end
      // track register writes
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          pct_pkg::REG_BCAST_THR: thr_r   = cfg_i.data;
          pct_pkg::REG_MIN_PRI:   floor_r = cfg_i.data;
          pct_pkg::REG_AUTO:      auto_r  = cfg_i.data[0];
          default: ;
        endcase
      end
      // predict each accepted item
      if (bid_i.valid && bid_i.ready) begin
        bid.bidder_id = bid_i.bidder_id;
        bid.prio      = bid_i.priority_req;
        bid.ctype     = bid_i.payload_kind;
        bid.handle    = bid_i.content_handle;
        bid.size      = bid_i.payload_len;
        awaited_q.push_back(predict_outcome(bid_i.command, bid));
      end
      outstanding_o = awaited_q.size();
    end
  end

endmodule

/* sim/tb_priority_competition_table.sv */
`timescale 1ns / 100ps

module tb_priority_competition_table;

  typedef logic [pct_pkg::PRI_W-1:0]  prio_t;
  typedef logic [pct_pkg::TYPE_W-1:0] kind_t;
  typedef logic [pct_pkg::SIZE_W-1:0] len_t;

  localparam int SLOTS        = 16;
  // two table scans when a bid resolves, plus margin
  localparam int RESULT_LAG   = 2 * (SLOTS + 3) + 4;
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASES       = 8;
  localparam int POOL         = 20;
  localparam logic [pct_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   outstanding;
  int   fail_count;

  // receiver stall pattern
  int ready_hold;
  int ready_cycle;
  int stall_level;

  // sender state
  int                        burst_left;
  bit                        gaps_on;
  int                        bid_floor;
  prio_t                     cfg_thr;
  prio_t                     cfg_floor;
  logic                      cfg_auto;
  logic [pct_pkg::MOD_W-1:0] bidder_pool [POOL];

  pct_cfg_if reg_bus ();
  pct_in_if  bid_bus ();
  pct_out_if result_bus ();

  priority_competition_table #(
    .SLOTS (SLOTS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (reg_bus),
    .in_i   (bid_bus),
    .out_o  (result_bus)
  );

  priority_competition_checker #(
    .SLOTS (SLOTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (reg_bus),
    .bid_i         (bid_bus),
    .res_i         (result_bus),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Toggle result ready in runs; the stall depth is redrawn at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      ready_hold       <= 0;
      ready_cycle      <= 0;
      stall_level      <= 0;
    end else begin
      ready_cycle <= ready_cycle + 1;
      if (ready_cycle % 300 == 299) stall_level <= $urandom_range(0, 2);
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
      end else if (stall_level == 0) begin
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= ~result_bus.ready;
        ready_hold       <= result_bus.ready ? $urandom_range(0, stall_level * 5)
                                             : $urandom_range(0, 6);
      end
    end
  end

  // Hold one item on the bid channel until its transfer
  task automatic offer(input logic [pct_pkg::CMD_W-1:0] cmd,
                       input logic [pct_pkg::MOD_W-1:0] mod,
                       input prio_t pri, input kind_t typ,
                       input logic [pct_pkg::HND_W-1:0] hnd, input len_t siz);
    bid_bus.valid          <= 1'b1;
    bid_bus.command        <= cmd;
    bid_bus.bidder_id      <= mod;
    bid_bus.priority_req   <= pri;
    bid_bus.payload_kind   <= typ;
    bid_bus.content_handle <= hnd;
    bid_bus.payload_len    <= siz;
    do @(posedge clk_i); while (!bid_bus.ready);
  endtask

  task automatic write_reg(input logic [pct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pct_pkg::CFG_DAT_W-1:0] val);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= val;
    do @(posedge clk_i); while (!reg_bus.ready);
  endtask

  task automatic set_config(input prio_t thr, input prio_t floor_val, input logic auto_on);
    write_reg(pct_pkg::REG_BCAST_THR, thr);
    write_reg(pct_pkg::REG_MIN_PRI, floor_val);
    write_reg(pct_pkg::REG_AUTO, {{(pct_pkg::CFG_DAT_W-1){1'b0}}, auto_on});
    reg_bus.valid <= 1'b0;
    bid_floor = int'((thr > floor_val) ? thr : floor_val);
  endtask

  // Drop valid and wait until every result is in and the block is quiet
  task automatic settle();
    bid_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (RESULT_LAG) @(posedge clk_i);
  endtask

  // Bias priorities around the acceptance bound so ties and near misses are common
  function automatic prio_t pick_priority(input int lo);
    int sel;
    int top;
    sel = $urandom_range(0, 99);
    top = (lo + 48 > 65535) ? 65535 : lo + 48;
    if (sel < 55) return prio_t'($urandom_range(lo, top));
    if (sel < 70) return prio_t'($urandom);
    if (sel < 85) begin
      if (lo == 0) return '0;
      return prio_t'($urandom_range((lo > 32) ? lo - 32 : 0, lo - 1));
    end
    return prio_t'((lo + sel % 2 > 65535) ? lo : lo + sel % 2);
  endfunction

  task automatic offer_random();
    int                        sel;
    logic [pct_pkg::CMD_W-1:0] cmd;
    logic [pct_pkg::MOD_W-1:0] mod;
    len_t                      siz;
    sel = $urandom_range(0, 99);
    if (sel < (cfg_auto ? 8 : 4)) cmd = pct_pkg::CMD_RESOLVE;
    else if (sel < 14)            cmd = pct_pkg::CMD_BCAST;
    else if (sel < 16)            cmd = CMD_UNKNOWN;
    else                          cmd = pct_pkg::CMD_COMPETE;
    mod = bidder_pool[$urandom_range(0, POOL - 1)];
    if ($urandom_range(0, 99) < 15) mod = $urandom;
    siz = len_t'($urandom);
    if ($urandom_range(0, 99) < 15) siz = '0;
    offer(cmd, mod, pick_priority(bid_floor), kind_t'($urandom), $urandom, siz);
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    reg_bus.valid          <= 1'b0;
    reg_bus.index          <= pct_pkg::REG_BCAST_THR;
    reg_bus.data           <= '0;
    bid_bus.valid          <= 1'b0;
    bid_bus.command        <= pct_pkg::CMD_COMPETE;
    bid_bus.bidder_id      <= '0;
    bid_bus.priority_req   <= '0;
    bid_bus.payload_kind   <= '0;
    bid_bus.content_handle <= '0;
    bid_bus.payload_len    <= '0;
    burst_left = 0;
    gaps_on    = 1'b1;
    cfg_thr    = pct_pkg::BCAST_THR_RST;
    cfg_floor  = pct_pkg::MIN_PRI_RST;
    cfg_auto   = 1'b1;
    bid_floor  = int'(pct_pkg::BCAST_THR_RST);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: empty resolve, unknown command, broadcasts, low and winning bids
    offer(pct_pkg::CMD_RESOLVE, 32'h1234_5678, 16'h0200, 8'h11, 32'hCAFE_0001, 16'h0010);
    offer(CMD_UNKNOWN, '1, '1, '1, '1, '1);
    offer(pct_pkg::CMD_BCAST, '0, '0, 8'hFF, 32'hFFFF_FFFF, 16'h0000);
    offer(pct_pkg::CMD_BCAST, '1, '1, 8'h00, 32'hFFFF_FFFF, 16'hFFFF);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_0005, 16'd127, 8'h22, 32'h0000_0022, 16'h0022);
    offer(pct_pkg::CMD_COMPETE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_0000, 16'd128, 8'h00, 32'h1234_5678, 16'h0000);

    // No thresholds, manual resolve: a zero priority wins, updates of one bidder
    settle();
    set_config(16'd0, 16'd0, 1'b0);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_0001, 16'd0, 8'h01, 32'h0000_0101, 16'h0001);
    offer(pct_pkg::CMD_RESOLVE, '0, '0, '0, '0, '0);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_00AA, 16'd200, 8'hA0, 32'hAAAA_0000, 16'h00AA);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_00BB, 16'd100, 8'hB0, 32'hBBBB_0000, 16'h00BB);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_00BB, 16'd300, 8'hB1, 32'hBBBB_0001, 16'h0000);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_00BB, 16'd200, 8'hB2, 32'hBBBB_0002, 16'h00B2);

    // Auto on with a tie at the top: the older entry wins, not the new bid
    settle();
    set_config(16'd0, 16'd0, 1'b1);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_00CC, 16'd200, 8'hC0, 32'hCCCC_0000, 16'h00CC);

    // Second threshold alone rejects
    settle();
    set_config(16'd0, 16'd300, 1'b1);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_0010, 16'd299, 8'h10, 32'h0000_1000, 16'h0100);
    offer(pct_pkg::CMD_COMPETE, 32'h0000_0011, 16'd300, 8'h11, 32'h0000_1100, 16'h0110);

    // Both thresholds at the top
    settle();
    set_config(16'hFFFF, 16'hFFFF, 1'b0);
    offer(pct_pkg::CMD_COMPETE, 32'h5A5A_5A5A, 16'hFFFE, 8'h5A, 32'h5A5A_0000, 16'h5A5A);
    offer(pct_pkg::CMD_COMPETE, 32'hA5A5_A5A5, 16'hFFFF, 8'hA5, 32'hA5A5_0000, 16'hA5A5);
    offer(pct_pkg::CMD_RESOLVE, '0, '0, '0, '0, '0);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin cfg_thr = prio_t'($urandom_range(0, 400));
                 cfg_floor = prio_t'($urandom_range(0, 400)); cfg_auto = 1'b1; end
        1: begin cfg_thr = '0; cfg_floor = '0; cfg_auto = 1'b0; end
        2: begin cfg_thr = '1; cfg_floor = '0; cfg_auto = 1'b1; end
        3: begin cfg_thr = '0; cfg_floor = '1; cfg_auto = 1'b0; end
        4: begin cfg_thr = prio_t'($urandom); cfg_floor = prio_t'($urandom);
                 cfg_auto = 1'($urandom_range(0, 1)); end
        5: begin cfg_thr = pct_pkg::BCAST_THR_RST; cfg_floor = pct_pkg::MIN_PRI_RST;
                 cfg_auto = 1'b1; end
        6: begin cfg_thr = prio_t'($urandom_range(0, 400));
                 cfg_floor = prio_t'($urandom_range(0, 400)); cfg_auto = 1'b0; end
        default: begin cfg_thr = prio_t'($urandom); cfg_floor = '0; cfg_auto = 1'b1; end
      endcase
      set_config(cfg_thr, cfg_floor, cfg_auto);
      gaps_on = (ph % 4) != 3;
      foreach (bidder_pool[k]) bidder_pool[k] = $urandom;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        // start a new burst, with a gap before it unless this phase runs back to back
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (gaps_on) begin
            bid_bus.valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 45)
                                                : $urandom_range(1, 12)) @(posedge clk_i);
          end
        end
        burst_left--;
        offer_random();
      end
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("priority_competition_table verification clean");
    end else begin
      $display("priority_competition_table verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("priority_competition_table verification failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/pct_pkg.sv
sv/pct_cfg_if.sv
sv/pct_in_if.sv
sv/pct_out_if.sv
sv/pct_scan.sv
sv/priority_competition_table.sv
sv/pct_checker.sv
sim/priority_competition_checker.sv
sim/tb_priority_competition_table.sv
